// ===== src/afm_pkg.sv =====
// Shared types, constants and the arctangent table for the transform matrix builder.
// Used by every module of the block; depends on nothing else.
package afm_pkg;

  localparam int MATRIX_DIM   = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int ANG_W        = 34;
  localparam int CNT_W        = $clog2(MATRIX_DIM * MATRIX_DIM);

  localparam logic signed [31:0] ONE_Q16  = 32'sd65536;
  localparam logic signed [33:0] DEG360   = 34'sd23592960;
  localparam logic signed [33:0] DEG180   = 34'sd11796480;
  localparam logic signed [33:0] DEG90    = 34'sd5898240;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [16:0] REC360  = 17'd93207;
  localparam logic [23:0] PI_FRAC = 24'd11262626;
  localparam logic [8:0]  PI_INT  = 9'd285;
  localparam logic [28:0] REC45   = 29'd381774871;

  typedef enum logic [1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_ROTATE    = 2'd1,
    FUNC_SCALE     = 2'd2,
    FUNC_UNKNOWN   = 2'd3
  } func_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef logic signed [17:0] trig_t;

  typedef struct packed {
    logic                    neg;
    logic signed [ANG_W-1:0] cx;
    logic signed [ANG_W-1:0] cy;
    logic signed [ANG_W-1:0] z;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0:  v = 34'sd843314857;
      1:  v = 34'sd497837829;
      2:  v = 34'sd263043837;
      3:  v = 34'sd133525159;
      4:  v = 34'sd67021687;
      5:  v = 34'sd33543516;
      6:  v = 34'sd16775851;
      7:  v = 34'sd8388437;
      8:  v = 34'sd4194283;
      9:  v = 34'sd2097149;
      10: v = 34'sd1048575;
      11: v = 34'sd524288;
      12: v = 34'sd262144;
      13: v = 34'sd131072;
      14: v = 34'sd65536;
      15: v = 34'sd32768;
      16: v = 34'sd16384;
      17: v = 34'sd8192;
      18: v = 34'sd4096;
      19: v = 34'sd2048;
      20: v = 34'sd1024;
      21: v = 34'sd512;
      22: v = 34'sd256;
      23: v = 34'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/afm_reduce.sv =====
// Angle lane: reduce a Q16.16 degree angle to [-90, 90] and convert to Q4.30 radians.
// Five register stages; depends on afm_pkg.
module afm_reduce (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [31:0]               deg,
  output logic signed [afm_pkg::ANG_W-1:0] z,
  output logic                             neg
);
  import afm_pkg::*;

  logic [17:0]        tt;
  logic [33:0]        qp;
  logic [7:0]         q1;
  logic signed [31:0] d1;

  logic signed [9:0]  qs;
  logic signed [33:0] r0, r1, r2c;
  logic               negc;
  logic signed [24:0] r2;
  logic               neg2;

  logic [24:0]        magw;
  logic [46:0]        m1;
  logic [31:0]        m2;
  logic               sg3, neg3;

  logic [47:0]        ws;
  logic [56:0]        pk;
  logic [31:0]        m2b;
  logic               sg4, neg4;
  logic [32:0]        zm;

  assign tt = {{2{deg[31]}}, deg[31:16]} + 18'd33120;
  assign qp = 34'(tt[16:0]) * 34'(REC360);

  always_comb begin
    qs = $signed({2'b00, q1}) - 10'sd92;
    r0 = 34'(d1) - 34'(qs) * DEG360;
    r1 = (r0 >= DEG180) ? r0 - DEG360 : r0;
    r2c  = r1;
    negc = 1'b0;
    if (r1 > DEG90) begin
      r2c  = DEG180 - r1;
      negc = 1'b1;
    end else if (r1 < -DEG90) begin
      r2c  = -DEG180 - r1;
      negc = 1'b1;
    end
  end

  assign magw = r2[24] ? -r2 : r2;
  assign ws   = 48'(m1) + 48'd5898240;
  assign zm   = {1'b0, m2b} + 33'(pk[56:34]);

  always_ff @(posedge clk) begin
    if (en) begin
      q1   <= qp[32:25];
      d1   <= deg;
      r2   <= r2c[24:0];
      neg2 <= negc;
      m1   <= 47'(magw[22:0]) * 47'(PI_FRAC);
      m2   <= 32'(magw[22:0]) * 32'(PI_INT);
      sg3  <= r2[24];
      neg3 <= neg2;
      pk   <= 57'(ws[45:18]) * 57'(REC45);
      m2b  <= m2;
      sg4  <= sg3;
      neg4 <= neg3;
      z    <= sg4 ? -$signed(34'(zm)) : $signed(34'(zm));
      neg  <= neg4;
    end
  end

endmodule

// ===== src/afm_cordic_cell.sv =====
// One CORDIC rotation step for the three angle lanes, registered.
// Cells are chained, one per step; depends on afm_pkg.
module afm_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                      clk,
  input  logic                      en,
  input  afm_pkg::cordic_t [2:0]    din,
  output afm_pkg::cordic_t [2:0]    dout
);
  import afm_pkg::*;

  localparam logic signed [ANG_W-1:0] ATAN = atan_q30(STEP);

  cordic_t [2:0] nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nxt[l].neg = din[l].neg;
      if (!din[l].z[ANG_W-1]) begin
        nxt[l].cx = din[l].cx - (din[l].cy >>> STEP);
        nxt[l].cy = din[l].cy + (din[l].cx >>> STEP);
        nxt[l].z  = din[l].z - ATAN;
      end else begin
        nxt[l].cx = din[l].cx + (din[l].cy >>> STEP);
        nxt[l].cy = din[l].cy - (din[l].cx >>> STEP);
        nxt[l].z  = din[l].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== src/afm_matrix.sv =====
// Rotation product Rx*Ry*Rz from CORDIC results, upper 3x3 block in Q2.16.
// Four register stages; depends on afm_pkg.
module afm_matrix (
  input  logic                        clk,
  input  logic                        en,
  input  afm_pkg::cordic_t [2:0]      din,
  output afm_pkg::trig_t   [8:0]      mat
);
  import afm_pkg::*;

  function automatic trig_t rnd16(input logic signed [37:0] v);
    logic signed [37:0] t;
    t = v + 38'sd32768;
    return t[33:16];
  endfunction

  function automatic trig_t q16(input logic signed [ANG_W-1:0] v);
    logic signed [ANG_W-1:0] t;
    logic signed [ANG_W-1:0] r;
    t = v + 34'sd8192;
    r = t >>> 14;
    if (r > 34'sd65536) r = 34'sd65536;
    if (r < -34'sd65536) r = -34'sd65536;
    return r[17:0];
  endfunction

  trig_t [2:0] c, s;
  trig_t [2:0] c1, s1;
  logic signed [35:0] pss, psc, pcs, pcc;
  trig_t [2:0] ra, rb, rc;
  logic signed [35:0] acz [3], bsz [3], asz [3], bcz [3];
  trig_t [2:0] rc2;

  always_comb begin
    ra[0] = c1[1];                   rb[0] = '0;    rc[0] = -s1[1];
    ra[1] = rnd16(38'(pss));         rb[1] = c1[0]; rc[1] = rnd16(38'(psc));
    ra[2] = rnd16(38'(pcs));         rb[2] = -s1[0]; rc[2] = rnd16(38'(pcc));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        c[l] <= din[l].neg ? -q16(din[l].cx) : q16(din[l].cx);
        s[l] <= q16(din[l].cy);
      end
      pss <= 36'(s[0]) * 36'(s[1]);
      psc <= 36'(s[0]) * 36'(c[1]);
      pcs <= 36'(c[0]) * 36'(s[1]);
      pcc <= 36'(c[0]) * 36'(c[1]);
      c1  <= c;
      s1  <= s;
      for (int i = 0; i < 3; i++) begin
        acz[i] <= 36'(ra[i]) * 36'(c1[2]);
        bsz[i] <= 36'(rb[i]) * 36'(s1[2]);
        asz[i] <= 36'(ra[i]) * 36'(s1[2]);
        bcz[i] <= 36'(rb[i]) * 36'(c1[2]);
      end
      rc2 <= rc;
      for (int i = 0; i < 3; i++) begin
        mat[3*i]     <= rnd16(38'(acz[i]) - 38'(bsz[i]));
        mat[3*i + 1] <= rnd16(38'(asz[i]) + 38'(bcz[i]));
        mat[3*i + 2] <= rc2[i];
      end
    end
  end

endmodule

// ===== src/affine_transform_matrix_builder.sv =====
// Each input transaction streams 16 elements (1 for an unknown operation), one per
// cycle while m_tready is high. The single output port limits throughput; the angle
// pipeline and CORDIC cell chain take a new input every cycle except while a finished
// input waits at the pipeline tail for the output port to finish the previous one.
// Reset (rst, synchronous): clears all valid flags and the output sequencer.
// Depends on afm_pkg, afm_reduce, afm_cordic_cell, afm_matrix.
module affine_transform_matrix_builder #(
  parameter int CORDIC_STEPS = afm_pkg::CORDIC_STEPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // x_value, y_value, z_value
  input  logic [1:0]  s_tuser,  // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // element_value, row_index, col_index, zero pad
  output logic [0:0]  m_tuser,  // status
  output logic        m_tlast   // last
);
  import afm_pkg::*;

  localparam int L = 9 + CORDIC_STEPS;
  localparam int NE = MATRIX_DIM * MATRIX_DIM;

  typedef struct packed {
    func_t              func;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } meta_t;

  meta_t              meta [L];
  logic [L-1:0]       vld;
  logic               adv, load;
  logic signed [ANG_W-1:0] zr [3];
  logic [2:0]         negr;
  cordic_t [2:0]      chain [CORDIC_STEPS+1];
  trig_t [8:0]        rmat;

  logic signed [31:0] elem [NE];
  logic signed [31:0] elem_next [NE];
  logic [CNT_W-1:0]   cnt;
  logic               busy, err;

  assign load     = vld[L-1] && (!busy || (m_tready && m_tlast));
  assign adv      = !vld[L-1] || load;
  assign s_tready = adv;

  afm_reduce u_rx (.clk, .en(adv), .deg(s_tdata[31:0]),  .z(zr[0]), .neg(negr[0]));
  afm_reduce u_ry (.clk, .en(adv), .deg(s_tdata[63:32]), .z(zr[1]), .neg(negr[1]));
  afm_reduce u_rz (.clk, .en(adv), .deg(s_tdata[95:64]), .z(zr[2]), .neg(negr[2]));

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      chain[0][l].neg = negr[l];
      chain[0][l].cx  = GAIN_Q30;
      chain[0][l].cy  = '0;
      chain[0][l].z   = zr[l];
    end
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    afm_cordic_cell #(.STEP(g)) u_cell (
      .clk, .en(adv), .din(chain[g]), .dout(chain[g+1])
    );
  end

  afm_matrix u_mat (.clk, .en(adv), .din(chain[CORDIC_STEPS]), .mat(rmat));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= '{func: func_t'(s_tuser), x: s_tdata[31:0], y: s_tdata[63:32],
                   z: s_tdata[95:64]};
      for (int i = 1; i < L; i++) meta[i] <= meta[i-1];
    end
  end

  always_comb begin
    for (int r = 0; r < MATRIX_DIM; r++) begin
      for (int c = 0; c < MATRIX_DIM; c++) begin
        elem_next[r*MATRIX_DIM + c] = (r == c) ? ONE_Q16 : '0;
        case (meta[L-1].func)
          FUNC_TRANSLATE: begin
            if (r == 3 && c == 0) elem_next[r*MATRIX_DIM + c] = meta[L-1].x;
            if (r == 3 && c == 1) elem_next[r*MATRIX_DIM + c] = meta[L-1].y;
            if (r == 3 && c == 2) elem_next[r*MATRIX_DIM + c] = meta[L-1].z;
          end
          FUNC_SCALE: begin
            if (r == 0 && c == 0) elem_next[r*MATRIX_DIM + c] = meta[L-1].x;
            if (r == 1 && c == 1) elem_next[r*MATRIX_DIM + c] = meta[L-1].y;
            if (r == 2 && c == 2) elem_next[r*MATRIX_DIM + c] = meta[L-1].z;
          end
          FUNC_ROTATE: begin
            if (r < 3 && c < 3) elem_next[r*MATRIX_DIM + c] = 32'(rmat[r*3 + c]);
          end
          default: elem_next[r*MATRIX_DIM + c] = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      err  <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
      err  <= (meta[L-1].func == FUNC_UNKNOWN);
    end else if (m_tvalid && m_tready) begin
      if (m_tlast) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      elem <= elem_next;
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = err || (cnt == CNT_W'(NE - 1));
  assign m_tuser  = err ? STATUS_ERR : STATUS_OK;
  assign m_tdata  = {4'b0000, cnt[1:0], cnt[3:2], (err ? 32'sd0 : elem[cnt])};

  a_more_beats: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("output run ended before last element");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && cnt == '0)
    else $error("error result not a single transaction");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> cnt == $past(cnt) + 1'b1)
    else $error("element counter skipped");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !vld[L-1] |-> s_tready)
    else $error("input stalled with empty pipeline tail");

endmodule

// ===== tb/testbench.sv =====
// Testbench for affine_transform_matrix_builder: drives translate, rotate, scale
// and unknown operations, predicts every matrix element and checks the stream.
// Depends on afm_pkg and the block's RTL.
module testbench;
  import afm_pkg::*;

  typedef struct {
    func_t       func;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } op_t;

  typedef struct {
    logic [31:0] value;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        status;
    logic        last;
  } elem_t;

  typedef longint mat_t[4][4];

  localparam longint Q16_ONE = 65536;
  localparam longint D360 = 23592960;
  localparam longint D180 = 11796480;
  localparam longint D90 = 5898240;
  localparam longint unsigned PI30 = 64'd3373259426;
  localparam longint GAIN30 = 652032874;
  localparam int WATCHDOG = 3000;

  localparam longint ATAN_TAB[24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048575, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;

  op_t   pending_ops[$];
  op_t   cur_op;
  elem_t expected_elems[$];
  bit    op_taken = 1'b0;
  bit    calm = 1'b0;
  int    in_gap = 0;
  int    out_gap = 0;
  int    errors = 0;
  int    quiet_cycles = 0;

  affine_transform_matrix_builder uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint q30_round(input longint v);
    longint r;
    r = (v + 8192) >>> 14;
    if (r > Q16_ONE) r = Q16_ONE;
    if (r < -Q16_ONE) r = -Q16_ONE;
    return r;
  endfunction

  function automatic void sin_cos(input longint deg, output longint sn, output longint cs);
    longint r, ang, cx, cy, dx, dy;
    longint unsigned mag;
    bit flip;
    flip = 1'b0;
    r = deg % D360;
    if (r < 0) r += D360;
    if (r >= D180) r -= D360;
    if (r > D90) begin
      r = D180 - r;
      flip = 1'b1;
    end else if (r < -D90) begin
      r = -D180 - r;
      flip = 1'b1;
    end
    mag = (r < 0) ? -r : r;
    ang = longint'((mag * PI30 + 64'(D180 / 2)) / 64'(D180));
    if (r < 0) ang = -ang;
    cx = GAIN30;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (ang >= 0) begin
        cx -= dx; cy += dy; ang -= ATAN_TAB[i];
      end else begin
        cx += dx; cy -= dy; ang += ATAN_TAB[i];
      end
    end
    cs = q30_round(cx);
    if (flip) cs = -cs;
    sn = q30_round(cy);
  endfunction

  function automatic void identity(output mat_t m);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        m[i][j] = (i == j) ? Q16_ONE : 0;
  endfunction

  function automatic void mat_product(output mat_t r, input mat_t a, input mat_t b);
    longint acc;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc += a[i][k] * b[k][j];
        acc = (acc + 32768) >>> 16;
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        r[i][j] = acc;
      end
  endfunction

  function automatic void build_matrix(input op_t op);
    mat_t m, rx, ry, rz, rxy;
    longint sn, cs;
    elem_t e;
    if (op.func == FUNC_UNKNOWN) begin
      e = '{32'd0, 2'd0, 2'd0, STATUS_ERR, 1'b1};
      expected_elems.push_back(e);
      return;
    end
    identity(m);
    case (op.func)
      FUNC_TRANSLATE: begin
        m[3][0] = longint'($signed(op.x));
        m[3][1] = longint'($signed(op.y));
        m[3][2] = longint'($signed(op.z));
      end
      FUNC_SCALE: begin
        m[0][0] = longint'($signed(op.x));
        m[1][1] = longint'($signed(op.y));
        m[2][2] = longint'($signed(op.z));
      end
      default: begin
        identity(rx); identity(ry); identity(rz);
        sin_cos(longint'($signed(op.x)), sn, cs);
        rx[1][1] = cs; rx[1][2] = sn; rx[2][1] = -sn; rx[2][2] = cs;
        sin_cos(longint'($signed(op.y)), sn, cs);
        ry[0][0] = cs; ry[2][0] = sn; ry[0][2] = -sn; ry[2][2] = cs;
        sin_cos(longint'($signed(op.z)), sn, cs);
        rz[0][0] = cs; rz[0][1] = sn; rz[1][0] = -sn; rz[1][1] = cs;
        mat_product(rxy, rx, ry);
        mat_product(m, rxy, rz);
      end
    endcase
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        e.value = m[i][j][31:0];
        e.row = i[1:0];
        e.col = j[1:0];
        e.status = STATUS_OK;
        e.last = (i == 3 && j == 3);
        expected_elems.push_back(e);
      end
  endfunction

  function automatic logic [31:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1440)) - 720) << 16;
      default: return 32'($signed($urandom_range(0, 32'd94371840)) - 32'sd47185920);
    endcase
  endfunction

  function automatic void add_op(input func_t f, input logic [31:0] x, y, z);
    op_t op;
    op = '{f, x, y, z};
    pending_ops.push_back(op);
  endfunction

  always @(posedge clk) begin
    elem_t e;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("testbench failed");
        $finish;
      end
      if (s_tvalid && s_tready) begin
        build_matrix(cur_op);
        op_taken = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_elems.size() == 0) begin
          $error("unexpected element transaction");
          errors++;
        end else begin
          e = expected_elems.pop_front();
          if (m_tdata[31:0] !== e.value) begin
            $error("element_value expected %h got %h", e.value, m_tdata[31:0]);
            errors++;
          end
          if (m_tdata[33:32] !== e.row) begin
            $error("row_index expected %0d got %0d", e.row, m_tdata[33:32]);
            errors++;
          end
          if (m_tdata[35:34] !== e.col) begin
            $error("col_index expected %0d got %0d", e.col, m_tdata[35:34]);
            errors++;
          end
          if (m_tuser[0] !== e.status) begin
            $error("status expected %0d got %0d", e.status, m_tuser[0]);
            errors++;
          end
          if (m_tlast !== e.last) begin
            $error("last expected %0d got %0d", e.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      calm = pending_ops.size() < 40;
      if (!s_tvalid || op_taken) begin
        op_taken = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          s_tdata <= {cur_op.z, cur_op.y, cur_op.x};
          s_tuser <= cur_op.func;
          s_tvalid <= 1'b1;
          if (!calm && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 6);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 6);
      end
    end
  end

  initial begin
    func_t f;
    add_op(FUNC_TRANSLATE, 32'h7FFFFFFF, 32'h80000000, 32'h00000000);
    add_op(FUNC_TRANSLATE, 32'hFFFFFFFF, 32'h00000001, 32'h80000000);
    add_op(FUNC_SCALE, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    add_op(FUNC_SCALE, 32'h00010000, 32'h00000000, 32'h00020000);
    add_op(FUNC_ROTATE, 32'd0, 32'd0, 32'd0);
    add_op(FUNC_ROTATE, 32'd90 << 16, -(32'd90 << 16), 32'd180 << 16);
    add_op(FUNC_ROTATE, -(32'd180 << 16), 32'd360 << 16, 32'd45 << 16);
    add_op(FUNC_ROTATE, 32'd270 << 16, 32'd135 << 16, -(32'd135 << 16));
    add_op(FUNC_ROTATE, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    add_op(FUNC_ROTATE, (32'd90 << 16) + 1, (32'd90 << 16) - 1, (32'd180 << 16) - 1);
    add_op(FUNC_UNKNOWN, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    add_op(FUNC_UNKNOWN, 32'd0, 32'd0, 32'd0);
    add_op(FUNC_ROTATE, 32'd30 << 16, 32'd60 << 16, -(32'd45 << 16));
    for (int n = 0; n < 270; n++) begin
      f = func_t'($urandom_range(0, 3));
      if (f == FUNC_ROTATE || $urandom_range(0, 2) == 0)
        add_op(f, rand_angle(), rand_angle(), rand_angle());
      else
        add_op(f, $urandom(), $urandom(), $urandom());
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_ops.size() == 0 && !s_tvalid && expected_elems.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_elems.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
